FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and codes for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // request op codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [1:0]         status;
      logic [4:0]         count;
      logic               is_empty;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic start;   // request transaction accepted this cycle
   } cmd_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      ring_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

FILE: sv/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

FILE: sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Handshake controller: takes one request, then holds the response until
// it is taken.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::cmd_type cmd
);
   import deq_pkg::*;

   typedef enum logic [0:0] {
      S_IDLE,
      S_BUSY
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.start = req_valid && !req_stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff     <= S_BUSY;
                  req_stall_ff <= 1'b1;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_BUSY: begin
               if (!rsp_stall) begin
                  state_ff     <= S_IDLE;
                  req_stall_ff <= 1'b0;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_stall_ff <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall_ff |-> !rsp_valid_ff)
      else $error("request side open while a response is pending");

   a_start_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall |=> !rsp_valid_ff)
      else $error("response repeated after delivery");
`endif

endmodule

FILE: sv/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Ring-buffer pointers, occupancy, entry RAM and response registers.
// ----------------------------------------------------------------------------
module deq_datapath (
   input  logic             clock,
   input  logic             reset,
   input  deq_pkg::cmd_type cmd,
   input  deq_pkg::req_type req,
   output deq_pkg::rsp_type rsp
);
   import deq_pkg::*;

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  back_ff, back_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [1:0]        status_ff, status_in;
   logic              dsel_ff, dsel_in;

   logic              we, re;
   logic [IDX_W-1:0]  waddr, raddr;
   logic [DATA_W-1:0] wdata, rdata;
   logic              full, empty;

   assign full  = (occ_ff == CNT_W'(DEPTH));
   assign empty = (occ_ff == '0);
   assign wdata = DATA_W'(req.value);   // sign-extends or truncates

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      occ_in    = occ_ff;
      status_in = status_ff;
      dsel_in   = dsel_ff;
      we        = 1'b0;
      re        = 1'b0;
      waddr     = back_ff;
      raddr     = front_ff;
      if (cmd.start) begin
         status_in = ST_OK;
         dsel_in   = 1'b0;
         unique case (req.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else if (req.op == OP_PUSH_FRONT) begin
                  front_in = ring_prev(front_ff);
                  waddr    = ring_prev(front_ff);
                  we       = 1'b1;
                  occ_in   = occ_ff + 1'b1;
               end else begin
                  back_in = ring_next(back_ff);
                  waddr   = back_ff;
                  we      = 1'b1;
                  occ_in  = occ_ff + 1'b1;
               end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  re      = 1'b1;
                  dsel_in = 1'b1;
                  if (req.op == OP_POP_FRONT || req.op == OP_PEEK_FRONT) begin
                     raddr = front_ff;
                  end else begin
                     raddr = ring_prev(back_ff);
                  end
                  if (req.op == OP_POP_FRONT) begin
                     front_in = ring_next(front_ff);
                     occ_in   = occ_ff - 1'b1;
                  end else if (req.op == OP_POP_BACK) begin
                     back_in = ring_prev(back_ff);
                     occ_in  = occ_ff - 1'b1;
                  end
               end
            end
            default: begin
               // unused op codes: no-op, ok status
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= '0;
         back_ff   <= '0;
         occ_ff    <= '0;
         status_ff <= ST_OK;
         dsel_ff   <= 1'b0;
      end else begin
         front_ff  <= front_in;
         back_ff   <= back_in;
         occ_ff    <= occ_in;
         status_ff <= status_in;
         dsel_ff   <= dsel_in;
      end
   end

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp.data     = dsel_ff ? signed'(32'(rdata)) : '0;
   assign rsp.status   = status_ff;
   assign rsp.count    = 5'(occ_ff);
   assign rsp.is_empty = empty;

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   a_full_push_refused: assert property (@(posedge clock) disable iff (reset)
      cmd.start && full && (req.op == OP_PUSH_FRONT || req.op == OP_PUSH_BACK)
      |=> status_ff == ST_FULL && occ_ff == $past(occ_ff))
      else $error("push into full queue changed occupancy");

   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      status_ff == ST_EMPTY |-> !dsel_ff)
      else $error("data selected on empty status");
`endif

endmodule

FILE: sv/double_ended_queue_core.sv
// Response: rsp_valid and the registered read data appear in the cycle after a request is accepted.
// Throughput: one request per response delivery; the single request/response handshake controller
// takes no new request until the response has been taken.
// Reset: synchronous, active high; clears pointers, occupancy and handshake state.
// Entry RAM contents are not cleared; only occupied entries are ever read.
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed words in a circular buffer.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_payload
);
   import deq_pkg::*;

   cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   deq_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_payload),
      .rsp   (rsp_payload)
   );

endmodule
